// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the min tracking stack modules
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mts_pkg.sv =====
// shared types and codes of the min tracking stack
// no dependencies; used by mts_ctrl, mts_datapath and min_tracking_stack
package mts_pkg;

   // default number of words held
   localparam int unsigned STACK_DEPTH_DEF = 128;

   // word widths
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned DEPTH_W = 8;

   // request opcodes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic push;
      logic pop;
      logic overflow;
      logic underflow;
      logic query;
      logic fill;
   } mts_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic empty;
   } mts_stat_type;

endpackage

// ===== rtl/core/mts_ctrl.sv =====
// controller of the min tracking stack: decodes requests, sequences pops
// depends on mts_pkg and assert_macros.svh
`include "assert_macros.svh"

module mts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           opcode,
   input  mts_pkg::mts_stat_type stat,
   output mts_pkg::mts_cmd_type  cmd,
   output logic                 busy
);
   import mts_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_FILL = 2'b10
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // next state and command decode
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (opcode)
                  OP_PUSH: begin
                     if (stat.full) cmd.overflow = 1'b1;
                     else           cmd.push     = 1'b1;
                  end
                  OP_POP: begin
                     if (stat.empty) begin
                        cmd.underflow = 1'b1;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = S_FILL;
                     end
                  end
                  OP_QUERY: cmd.query = 1'b1;
                  default:  cmd.query = 1'b1;
               endcase
            end
         end
         S_FILL: begin
            // new tops come back from the stores this cycle
            cmd.fill = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff == S_FILL);

   // checks
   `ASSERT_CLK(a_fill_one_cycle, clock, reset, (state_ff == S_FILL) |=> (state_ff == S_IDLE), "fill state held more than one cycle")
   `ASSERT_CLK(a_pop_enters_fill, clock, reset, cmd.pop |=> cmd.fill, "successful pop not followed by fill")
   `ASSERT_NEVER(a_quiet_in_fill, clock, reset, busy && (cmd.push || cmd.pop || cmd.query), "request decoded while busy")
endmodule

// ===== rtl/core/mts_datapath.sv =====
// datapath of the min tracking stack: value and minimum stores, counts,
// cached tops and the response registers; depends on mts_pkg, assert_macros.svh
`include "assert_macros.svh"

module mts_datapath #(
   parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mts_pkg::mts_cmd_type                cmd,
   input  logic signed [mts_pkg::WORD_W-1:0]   push_value,
   output mts_pkg::mts_stat_type               stat,
   output logic                               rsp_strobe,
   output logic signed [mts_pkg::WORD_W-1:0]   rsp_popped_value,
   output logic signed [mts_pkg::WORD_W-1:0]   rsp_current_min,
   output logic [mts_pkg::DEPTH_W-1:0]         rsp_depth,
   output logic                               rsp_is_empty,
   output logic [1:0]                         rsp_status
);
   import mts_pkg::*;

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   // stores
   logic [WORD_W-1:0] val_mem [STACK_DEPTH];
   logic [WORD_W-1:0] min_mem [STACK_DEPTH];
   logic [WORD_W-1:0] val_rd_ff;
   logic [WORD_W-1:0] min_rd_ff;

   // counts and cached top words
   logic [CW-1:0]            val_cnt_ff, val_cnt_in;
   logic [CW-1:0]            min_cnt_ff, min_cnt_in;
   logic signed [WORD_W-1:0] top_val_ff, top_val_in;
   logic signed [WORD_W-1:0] top_min_ff, top_min_in;
   logic                     min_pop_ff, min_pop_in;

   // response registers
   logic                     strobe_ff, strobe_in;
   logic signed [WORD_W-1:0] popped_ff, popped_in;
   logic signed [WORD_W-1:0] cur_min_ff, cur_min_in;
   logic [DEPTH_W-1:0]       depth_ff, depth_in;
   logic                     empty_ff, empty_in;
   logic [1:0]               status_ff, status_in;

   logic min_push;
   logic min_hit;
   logic [AW-1:0] val_wr_addr;
   logic [AW-1:0] min_wr_addr;
   logic [AW-1:0] val_rd_addr;
   logic [AW-1:0] min_rd_addr;
   logic [CW-1:0] val_cnt_m2;
   logic [CW-1:0] min_cnt_m2;

   assign stat.full  = (val_cnt_ff >= CW'(STACK_DEPTH));
   assign stat.empty = (val_cnt_ff == '0);

   // push goes onto the minimum store when it is empty or not above the minimum
   assign min_push = ((min_cnt_ff == '0) || (push_value <= top_min_ff))
                     && (min_cnt_ff < CW'(STACK_DEPTH));
   // pop removes the minimum when the top word equals it
   assign min_hit  = (min_cnt_ff != '0) && (top_val_ff == top_min_ff);

   assign val_wr_addr = val_cnt_ff[AW-1:0];
   assign min_wr_addr = min_cnt_ff[AW-1:0];
   assign val_cnt_m2  = val_cnt_ff - CW'(2);
   assign min_cnt_m2  = min_cnt_ff - CW'(2);
   assign val_rd_addr = val_cnt_m2[AW-1:0];
   assign min_rd_addr = min_cnt_m2[AW-1:0];

   // store writes on push, new-top reads on pop
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         val_mem[val_wr_addr] <= push_value;
         if (min_push) min_mem[min_wr_addr] <= push_value;
      end
      if (cmd.pop) begin
         val_rd_ff <= val_mem[val_rd_addr];
         min_rd_ff <= min_mem[min_rd_addr];
      end
   end

   // state update and response word
   always_comb begin
      val_cnt_in = val_cnt_ff;
      min_cnt_in = min_cnt_ff;
      top_val_in = top_val_ff;
      top_min_in = top_min_ff;
      min_pop_in = min_pop_ff;
      strobe_in  = 1'b0;
      popped_in  = popped_ff;
      cur_min_in = cur_min_ff;
      depth_in   = depth_ff;
      empty_in   = empty_ff;
      status_in  = status_ff;

      if (cmd.push) begin
         val_cnt_in = val_cnt_ff + CW'(1);
         top_val_in = push_value;
         if (min_push) begin
            min_cnt_in = min_cnt_ff + CW'(1);
            top_min_in = push_value;
         end
         popped_in = '0;
         status_in = ST_OK;
      end
      if (cmd.overflow) begin
         popped_in = '0;
         status_in = ST_OVERFLOW;
      end
      if (cmd.underflow) begin
         popped_in = '0;
         status_in = ST_UNDERFLOW;
      end
      if (cmd.query) begin
         popped_in = '0;
         status_in = ST_OK;
      end
      if (cmd.pop) begin
         val_cnt_in = val_cnt_ff - CW'(1);
         if (min_hit) min_cnt_in = min_cnt_ff - CW'(1);
         min_pop_in = min_hit;
         popped_in  = top_val_ff;
         status_in  = ST_OK;
      end
      if (cmd.fill) begin
         top_val_in = val_rd_ff;
         if (min_pop_ff) top_min_in = min_rd_ff;
      end

      // everything but the pop issue cycle answers now
      if (cmd.push || cmd.overflow || cmd.underflow || cmd.query || cmd.fill) begin
         strobe_in  = 1'b1;
         cur_min_in = ((val_cnt_in != '0) && (min_cnt_in != '0)) ? top_min_in : '0;
         depth_in   = DEPTH_W'(val_cnt_in);
         empty_in   = (val_cnt_in == '0);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         val_cnt_ff <= '0;
         min_cnt_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         val_cnt_ff <= val_cnt_in;
         min_cnt_ff <= min_cnt_in;
         strobe_ff  <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_val_ff <= top_val_in;
      top_min_ff <= top_min_in;
      min_pop_ff <= min_pop_in;
      popped_ff  <= popped_in;
      cur_min_ff <= cur_min_in;
      depth_ff   <= depth_in;
      empty_ff   <= empty_in;
      status_ff  <= status_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_current_min  = cur_min_ff;
   assign rsp_depth        = depth_ff;
   assign rsp_is_empty     = empty_ff;
   assign rsp_status       = status_ff;

   // checks
   `ASSERT_NEVER(a_min_cnt_le_val_cnt, clock, reset, min_cnt_ff > val_cnt_ff, "minimum count above value count")
   `ASSERT_CLK(a_min_empty_iff_empty, clock, reset, (min_cnt_ff == '0) == (val_cnt_ff == '0), "minimum store empty while values held")
   `ASSERT_CLK(a_fill_answers, clock, reset, cmd.fill |=> strobe_ff, "fill did not produce a response word")
endmodule

// ===== rtl/core/min_tracking_stack.sv =====
// top level of the min tracking stack: controller plus datapath
// depends on mts_pkg, mts_ctrl and mts_datapath
//
// usage:
//   a request word (req_opcode, req_push_value) is taken at a rising edge
//   with start high and busy low. opcodes: push, pop, query (code three is
//   a query). every request yields one response word on the rsp_ ports,
//   shown for exactly one cycle with rsp_strobe high; the receiver has no
//   way to stall it and must take it in that cycle.
// request flow:
//   push, query and rejected requests answer in the cycle after acceptance and
//   leave busy low, so one of these can be taken every cycle.
//   a successful pop holds busy high for one cycle while the new tops of the
//   value and minimum stores come back from their synchronous read ports, and
//   answers after that fill state; no request is taken until the pop is done.
// reset:
//   synchronous, active high; empties the stack. store contents are not
//   cleared; an entry read before it is written is never used.
module min_tracking_stack #(
   parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_opcode,
   input  logic signed [mts_pkg::WORD_W-1:0]   req_push_value,
   output logic                               rsp_strobe,
   output logic signed [mts_pkg::WORD_W-1:0]   rsp_popped_value,
   output logic signed [mts_pkg::WORD_W-1:0]   rsp_current_min,
   output logic [mts_pkg::DEPTH_W-1:0]         rsp_depth,
   output logic                               rsp_is_empty,
   output logic [1:0]                         rsp_status
);
   import mts_pkg::*;

   mts_cmd_type  cmd;
   mts_stat_type stat;

   // request decode and pop sequencing
   mts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   // stores, counts and response registers
   mts_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .push_value       (req_push_value),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_value (rsp_popped_value),
      .rsp_current_min  (rsp_current_min),
      .rsp_depth        (rsp_depth),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_status       (rsp_status)
   );
endmodule
